// ===== sv/ppmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmt_pkg
// shared codes, token type and helpers of the prefix pattern match table
// ----------------------------------------------------------------------------
package ppmt_pkg;

   localparam int unsigned VALUE_W = 128;
   localparam int unsigned CODE_W  = 4;
   localparam int unsigned OP_W    = 2;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [VALUE_W-1:0] value_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;
   localparam op_type OP_NONE   = 2'd3;

   // one item travelling down the cell row
   typedef struct packed {
      logic      valid;
      op_type    op;
      code_type  code;
      logic      overflow;
      logic      hit;
      value_type value;      // pattern or query bytes, first byte in the top bits
   } token_type;

   // top (code+1) bytes of a 128-bit word
   function automatic value_type prefix_mask(input code_type code);
      return {VALUE_W{1'b1}} << {~code, 3'b000};
   endfunction

   // move the low (code+1) bytes of a pattern to the top of the word
   function automatic value_type align_pattern(input value_type value,
                                               input code_type code);
      return value << {~code, 3'b000};
   endfunction

endpackage

// ===== sv/ppmt_cell.sv =====
// ----------------------------------------------------------------------------
// ppmt_cell
// one table entry: captures an append aimed at its slot, matches queries
// ----------------------------------------------------------------------------
module ppmt_cell #(
   parameter int CELL_INDEX = 0,
   parameter int COUNT_W    = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ppmt_pkg::token_type  tok_in,
   input  logic [COUNT_W-1:0]   count_in,
   output ppmt_pkg::token_type  tok_out,
   output logic [COUNT_W-1:0]   count_out
);

   ppmt_pkg::value_type entry_value_ff;
   ppmt_pkg::code_type  entry_code_ff;
   ppmt_pkg::token_type tok_ff;
   ppmt_pkg::token_type tok_in_next;
   logic [COUNT_W-1:0]  count_ff;
   logic                active;
   logic                match;
   logic                write_en;

   // entry is live for this item when its slot lies below the item's count
   assign active = count_in > COUNT_W'(CELL_INDEX);
   assign match  = ((tok_in.value ^ entry_value_ff)
                    & ppmt_pkg::prefix_mask(entry_code_ff)) == '0;

   // an append carries the count after it, so its slot is count minus one
   assign write_en = advance && tok_in.valid && (tok_in.op == ppmt_pkg::OP_APPEND)
                     && !tok_in.overflow && (count_in == COUNT_W'(CELL_INDEX + 1));

   always_comb begin
      tok_in_next     = tok_in;
      tok_in_next.hit = tok_in.hit | (tok_in.valid && (tok_in.op == ppmt_pkg::OP_QUERY)
                                      && active && match);
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_value_ff <= tok_in.value;
         entry_code_ff  <= tok_in.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff   <= tok_in_next;
         count_ff <= count_in;
      end
   end

   assign tok_out   = tok_ff;
   assign count_out = count_ff;

endmodule

// ===== sv/prefix_pattern_match_table.sv =====
// ----------------------------------------------------------------------------
// prefix_pattern_match_table
// table of 1..16 byte patterns with clear, append and prefix query
// ----------------------------------------------------------------------------
// Each request transfer carries one operation (clear, append or query) and
// gives exactly one response transfer, in order. Entries sit in a row of
// MAX_ENTRIES cells; an item first lands in an intake register, then walks the
// row one cell per cycle while the row advances; rsp_tvalid rises once the
// item sits in the last cell's register. The row is a pipeline: one request
// is taken every cycle unless a response is stalled, and the whole row,
// including the intake, holds while a response waits for rsp_tready. A
// query hits when its first N bytes equal any stored N-byte pattern; an
// append to a full table is dropped and flagged as overflow. entry_count is
// the low seven bits of the number of patterns held after the item.
module prefix_pattern_match_table #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // pattern_len_code[3:0], pattern_upper[67:4], pattern_lower[131:68],
   // data_high[195:132], data_low[259:196], zero fill
   input  logic [263:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0], entry_count[7:1], overflow[8], zero fill
   output logic [15:0]  rsp_tdata
);

   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_ENTRIES);

   // unpacked request fields
   ppmt_pkg::op_type    req_op;
   ppmt_pkg::code_type  req_code;
   logic [63:0]         req_pattern_upper;
   logic [63:0]         req_pattern_lower;
   logic [63:0]         req_data_high;
   logic [63:0]         req_data_low;

   assign req_op            = req_tuser;
   assign req_code          = req_tdata[3:0];
   assign req_pattern_upper = req_tdata[67:4];
   assign req_pattern_lower = req_tdata[131:68];
   assign req_data_high     = req_tdata[195:132];
   assign req_data_low      = req_tdata[259:196];

   // token chain: stage 0 is the intake register, stage MAX_ENTRIES the output
   ppmt_pkg::token_type tok   [MAX_ENTRIES+1];
   logic [COUNT_W-1:0]  count [MAX_ENTRIES+1];

   logic                advance;
   logic                accept;
   logic [COUNT_W-1:0]  valid_count_ff;
   logic [COUNT_W-1:0]  valid_count_in;
   logic                overflow_in;
   ppmt_pkg::token_type head_tok_ff;
   ppmt_pkg::token_type head_tok_in;
   logic [COUNT_W-1:0]  head_count_ff;

   // whole row moves together; it stops only while a response is refused
   assign advance    = !tok[MAX_ENTRIES].valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   // pattern count after this item
   always_comb begin
      valid_count_in = valid_count_ff;
      overflow_in    = 1'b0;
      unique case (req_op)
         ppmt_pkg::OP_CLEAR: begin
            valid_count_in = '0;
         end
         ppmt_pkg::OP_APPEND: begin
            if (valid_count_ff == FULL_COUNT) begin
               overflow_in = 1'b1;
            end else begin
               valid_count_in = valid_count_ff + COUNT_W'(1);
            end
         end
         ppmt_pkg::OP_QUERY,
         ppmt_pkg::OP_NONE: begin
            valid_count_in = valid_count_ff;
         end
         default: begin
            valid_count_in = valid_count_ff;
         end
      endcase
   end

   // intake token; appends are stored left-aligned so cells need no shifter
   always_comb begin
      head_tok_in          = '0;
      head_tok_in.valid    = accept;
      head_tok_in.op       = req_op;
      head_tok_in.code     = req_code;
      head_tok_in.overflow = overflow_in;
      head_tok_in.hit      = 1'b0;
      if (req_op == ppmt_pkg::OP_QUERY) begin
         head_tok_in.value = {req_data_high, req_data_low};
      end else begin
         head_tok_in.value = ppmt_pkg::align_pattern({req_pattern_upper, req_pattern_lower},
                                                     req_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_count_ff <= '0;
      end else if (accept) begin
         valid_count_ff <= valid_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_tok_ff.valid <= 1'b0;
      end else if (advance) begin
         head_tok_ff   <= head_tok_in;
         head_count_ff <= valid_count_in;
      end
   end

   assign tok[0]   = head_tok_ff;
   assign count[0] = head_count_ff;

   // row of entry cells
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      ppmt_cell #(
         .CELL_INDEX (i),
         .COUNT_W    (COUNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .tok_in    (tok[i]),
         .count_in  (count[i]),
         .tok_out   (tok[i+1]),
         .count_out (count[i+1])
      );
   end

   // response from the last cell
   assign rsp_tvalid = tok[MAX_ENTRIES].valid;
   assign rsp_tdata  = {7'b0000000,
                        tok[MAX_ENTRIES].overflow,
                        7'(count[MAX_ENTRIES]),
                        tok[MAX_ENTRIES].hit};

endmodule

// ===== sv/ppmt_checker.sv =====
// ----------------------------------------------------------------------------
// ppmt_checker
// port-level checks of the prefix pattern match table
// ----------------------------------------------------------------------------
module ppmt_checker #(
   parameter int MAX_ENTRIES = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   localparam logic [6:0] FULL_COUNT = 7'(MAX_ENTRIES);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid just after reset");

   // a dropped append only happens with a full table
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7:1] == FULL_COUNT)
      else $error("overflow without a full table");

   // a hit needs a stored pattern, and never comes with overflow
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[8]
                    && (MAX_ENTRIES % 128 == 0 || rsp_tdata[7:1] != 7'd0))
      else $error("hit on an empty table or together with overflow");

   // a refused response stays put
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind prefix_pattern_match_table ppmt_checker #(
   .MAX_ENTRIES (MAX_ENTRIES)
) u_ppmt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
